>>> hdl/mtclcd_pkg.sv
// ----------------------------------------------------------------------------
// mtclcd_pkg
// Types, codes and the byte expansion shared by the serial LCD writer.
// ----------------------------------------------------------------------------
package mtclcd_pkg;

	localparam int unsigned FRAME_BITS = 40;
	localparam int unsigned COUNT_BITS = 6;

	localparam logic [1:0] MODE_PIXEL = 2'd0;
	localparam logic [1:0] MODE_CMD   = 2'd1;
	localparam logic [1:0] MODE_DATA  = 2'd2;

	localparam logic [7:0] ROW_BYTES_RESET = 8'd20;
	localparam logic [7:0] PAD_BYTE        = 8'h00;

	localparam logic [COUNT_BITS-1:0] BITS_ONE_BYTE   = 6'd8;
	localparam logic [COUNT_BITS-1:0] BITS_PIXEL      = 6'd32;
	localparam logic [COUNT_BITS-1:0] BITS_PIXEL_PAD  = 6'd40;

	// Everything the serializer needs to send the bytes of one transaction.
	typedef struct packed {
		logic [FRAME_BITS-1:0] bits;
		logic [COUNT_BITS-1:0] nbits;
		logic                  sel;
	} frame_t;

	// One pixel pair becomes a byte: high nibble from the left pixel.
	function automatic logic [7:0] pixel_pair(input logic left, input logic right);
		pixel_pair = {{4{left}}, {4{right}}};
	endfunction

	// Builds the serial frame for one input, left aligned so the MSB goes first.
	function automatic frame_t build_frame(input logic [1:0] mode, input logic [7:0] value,
		input logic pad);
		frame_t f;
		f.bits  = {value, 32'h0};
		f.nbits = BITS_ONE_BYTE;
		f.sel   = 1'b1;
		unique case (mode)
			MODE_CMD: begin
				f.sel = 1'b0;
			end
			MODE_PIXEL: begin
				f.bits = {pixel_pair(value[7], value[6]), pixel_pair(value[5], value[4]),
					pixel_pair(value[3], value[2]), pixel_pair(value[1], value[0]),
					PAD_BYTE};
				f.nbits = pad ? BITS_PIXEL_PAD : BITS_PIXEL;
			end
			default: begin
				f.sel = 1'b1;
			end
		endcase
		build_frame = f;
	endfunction

endpackage

>>> hdl/mtclcd_shifter.sv
// ----------------------------------------------------------------------------
// mtclcd_shifter
// Serializes a loaded frame one bit per accepted result, with byte framing.
// ----------------------------------------------------------------------------
module mtclcd_shifter (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load_valid,
	output logic                load_ready,
	input  mtclcd_pkg::frame_t  frame,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                serial_bit,
	output logic                select_data,
	output logic                byte_first,
	output logic                byte_last,
	output logic                run_last
);

	logic                                    busy_q;
	logic [mtclcd_pkg::FRAME_BITS-1:0]       bits_q;
	logic [mtclcd_pkg::COUNT_BITS-1:0]       remain_q;
	logic [2:0]                              bitpos_q;
	logic                                    sel_q;
	logic                                    last_bit;

	assign last_bit   = (remain_q == mtclcd_pkg::COUNT_BITS'(1));
	assign load_ready = !busy_q || (out_ready && last_bit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			remain_q <= '0;
			bitpos_q <= '0;
		end else if (load_valid && load_ready) begin
			busy_q   <= 1'b1;
			remain_q <= frame.nbits;
			bitpos_q <= '0;
		end else if (busy_q && out_ready) begin
			busy_q   <= !last_bit;
			remain_q <= remain_q - mtclcd_pkg::COUNT_BITS'(1);
			bitpos_q <= bitpos_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_valid && load_ready) begin
			bits_q <= frame.bits;
			sel_q  <= frame.sel;
		end else if (busy_q && out_ready) begin
			bits_q <= {bits_q[mtclcd_pkg::FRAME_BITS-2:0], 1'b0};
		end
	end

	assign out_valid   = busy_q;
	assign serial_bit  = bits_q[mtclcd_pkg::FRAME_BITS-1];
	assign select_data = sel_q;
	assign byte_first  = (bitpos_q == 3'd0);
	assign byte_last   = (bitpos_q == 3'd7);
	assign run_last    = last_bit;

endmodule

>>> hdl/mono_to_color_lcd_serial_writer_unit.sv
// ----------------------------------------------------------------------------
// mono_to_color_lcd_serial_writer_unit
// Serial LCD byte writer with monochrome to 4-bit-per-pixel expansion.
// ----------------------------------------------------------------------------
// The first serial bit is offered once the input has passed the input register
// and been loaded into the bit shifter. The shifter sends one serial bit per
// cycle while out_ready is high: 8 bits for a command or raw data byte, 32 for
// a pixel byte, 40 for a pixel byte that closes a row. A new input is taken
// while the previous one shifts. Reset clears the column counter, the pipeline
// valid flags and sets the row length to 20; there is no clearing pass.
module mono_to_color_lcd_serial_writer_unit (
	input  logic       clk,
	input  logic       arst_n,
	// Configuration: row length; the user writes it only while the block is idle, which the block does not enforce.
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] cfg_data,
	// Input channel.
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] mode,
	input  logic [7:0] value,
	// Result channel, one transaction per serial bit.
	output logic       out_valid,
	input  logic       out_ready,
	output logic       serial_bit,
	output logic       select_data,
	output logic       byte_first,
	output logic       byte_last,
	output logic       run_last
);

	logic [7:0]          row_bytes_q;
	logic [7:0]          column_count_q;
	logic [8:0]          col_next;
	logic [8:0]          row_limit;
	logic                row_pad;
	logic                in_fire;
	logic                item_known;
	logic                valid_s1;
	logic                load_ready;
	mtclcd_pkg::frame_t  frame_s1;

	// The register is always writable; the user only writes it while idle.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_bytes_q <= mtclcd_pkg::ROW_BYTES_RESET;
		end else if (cfg_valid) begin
			row_bytes_q <= cfg_data;
		end
	end

	// A row length of zero stands for 256 bytes. The pad byte follows the
	// pixel byte that brings the count to the row length or past it, which
	// also covers a row length lowered below the current count.
	assign col_next  = {1'b0, column_count_q} + 9'd1;
	assign row_limit = (row_bytes_q == 8'd0) ? 9'd256 : {1'b0, row_bytes_q};
	assign row_pad   = (col_next >= row_limit);

	// The input register may take a new item when it is empty or when its
	// frame moves into the shifter in this same cycle.
	assign in_ready   = !valid_s1 || load_ready;
	assign in_fire    = in_valid && in_ready;
	assign item_known = (mode == mtclcd_pkg::MODE_PIXEL) || (mode == mtclcd_pkg::MODE_CMD)
		|| (mode == mtclcd_pkg::MODE_DATA);

	// Only pixel bytes advance the column counter; the unused mode code is
	// accepted and dropped without any result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_count_q <= '0;
		end else if (in_fire && (mode == mtclcd_pkg::MODE_PIXEL)) begin
			column_count_q <= row_pad ? 8'd0 : col_next[7:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= item_known;
		end else if (load_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	// The byte expansion is done on the way into the input register.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			frame_s1 <= mtclcd_pkg::build_frame(mode, value, row_pad);
		end
	end

	mtclcd_shifter u_shifter (
		.clk         (clk),
		.arst_n      (arst_n),
		.load_valid  (valid_s1),
		.load_ready  (load_ready),
		.frame       (frame_s1),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.serial_bit  (serial_bit),
		.select_data (select_data),
		.byte_first  (byte_first),
		.byte_last   (byte_last),
		.run_last    (run_last)
	);

endmodule
